// File: rtl/mixed_radix_time_add_sub_top_macros.svh
// assertion macros shared by the time add/sub rtl
`ifndef MIXED_RADIX_TIME_ADD_SUB_TOP_MACROS_SVH
`define MIXED_RADIX_TIME_ADD_SUB_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define MRT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define MRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mrt_pkg.sv
// types and constants for the mixed-radix time add/sub pipeline
package mrt_pkg;

   // operand and total width in milliseconds, magnitude width
   localparam int OPD_W = 34;
   localparam int MAG_W = 33;

   // unsigned digit widths inside the pipeline
   localparam int HRS_W   = 12;
   localparam int TOT_S_W = 12;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int MS_W    = 10;
   localparam int HMS_REM_W = 22;

   // port field widths
   localparam int HOURS_FW  = 11;
   localparam int MINSEC_FW = 7;
   localparam int MILLIS_FW = 11;

   localparam int HOUR_MS = 3600000;

   localparam logic signed [OPD_W-1:0] HOUR_MS_S = 34'sd3600000;
   localparam logic signed [OPD_W-1:0] MIN_MS_S  = 34'sd60000;
   localparam logic signed [OPD_W-1:0] SEC_MS_S  = 34'sd1000;

   // reciprocal constants: divide by 3600000, 1000 and 60 after a pre-shift
   localparam int HR_SHIFT = 7;
   localparam int HR_MUL_W = 28;
   localparam int HR_K     = 42;
   localparam int HR_DIV_W = 22;
   localparam logic [HR_MUL_W-1:0] HR_RECIP = 28'd156374988;
   localparam logic [HR_DIV_W-1:0] HR_DIV   = 22'd3600000;

   localparam int SC_SHIFT = 3;
   localparam int SC_MUL_W = 20;
   localparam int SC_K     = 26;
   localparam int SC_DIV_W = 10;
   localparam logic [SC_MUL_W-1:0] SC_RECIP = 20'd536871;
   localparam logic [SC_DIV_W-1:0] SC_DIV   = 10'd1000;

   localparam int MN_SHIFT = 2;
   localparam int MN_MUL_W = 11;
   localparam int MN_K     = 14;
   localparam int MN_DIV_W = 6;
   localparam logic [MN_MUL_W-1:0] MN_RECIP = 11'd1093;
   localparam logic [MN_DIV_W-1:0] MN_DIV   = 6'd60;

   typedef struct packed {
      logic ovf;
      logic greater;
      logic equal;
      logic neg;
   } flags_type;

   typedef struct packed {
      flags_type         flags;
      logic [HRS_W-1:0]  hours;
   } sside_type;

   typedef struct packed {
      flags_type         flags;
      logic [HRS_W-1:0]  hours;
      logic [MS_W-1:0]   millis;
   } mside_type;

endpackage

// File: rtl/mrt_cdiv.sv
// three-stage divide by a constant: reciprocal multiply, back-multiply, remainder
`include "mixed_radix_time_add_sub_top_macros.svh"

module mrt_cdiv #(
   parameter int NUM_W = 33,
   parameter int SHIFT = 7,
   parameter int MUL_W = 28,
   parameter logic [MUL_W-1:0] RECIP = 156374988,
   parameter int K = 42,
   parameter int DIV_W = 22,
   parameter logic [DIV_W-1:0] DIVISOR = 3600000,
   parameter int QUO_W = 12,
   parameter int REM_W = 22,
   parameter type side_type = logic
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             valid_in,
   input  logic [NUM_W-1:0] num_in,
   input  side_type         side_in,
   output logic             valid_out,
   output logic [QUO_W-1:0] quo_out,
   output logic [REM_W-1:0] rem_out,
   output side_type         side_out
);

   localparam int X_W = NUM_W - SHIFT;
   localparam int P_W = X_W + MUL_W;
   localparam int B_W = QUO_W + DIV_W;

   logic             valid_a_ff, valid_b_ff, valid_c_ff;
   logic [P_W-1:0]   prod_a_in, prod_a_ff;
   logic [NUM_W-1:0] num_a_ff, num_b_ff;
   side_type         side_a_ff, side_b_ff, side_c_ff;
   logic [QUO_W-1:0] quo_b_in, quo_b_ff, quo_c_ff;
   logic [B_W-1:0]   back_b_in, back_b_ff;
   logic [NUM_W-1:0] diff_c;
   logic [REM_W-1:0] rem_c_in, rem_c_ff;

   // quotient estimate, exact for the operand range
   assign prod_a_in = P_W'(num_in[NUM_W-1:SHIFT]) * P_W'(RECIP);
   assign quo_b_in  = prod_a_ff[K +: QUO_W];
   assign back_b_in = B_W'(quo_b_in) * B_W'(DIVISOR);
   assign diff_c    = num_b_ff - NUM_W'(back_b_ff);
   assign rem_c_in  = diff_c[REM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else if (adv) begin
         valid_a_ff <= valid_in;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_a_ff <= prod_a_in;
         num_a_ff  <= num_in;
         side_a_ff <= side_in;
         quo_b_ff  <= quo_b_in;
         back_b_ff <= back_b_in;
         num_b_ff  <= num_a_ff;
         side_b_ff <= side_a_ff;
         quo_c_ff  <= quo_b_ff;
         rem_c_ff  <= rem_c_in;
         side_c_ff <= side_b_ff;
      end
   end

   assign valid_out = valid_c_ff;
   assign quo_out   = quo_c_ff;
   assign rem_out   = rem_c_ff;
   assign side_out  = side_c_ff;

   `MRT_ASSERT_NOW(a_back_not_above_num, valid_b_ff, back_b_ff <= num_b_ff,
      "quotient estimate too large")
   `MRT_ASSERT_NOW(a_rem_below_divisor, valid_c_ff, rem_c_ff < DIVISOR,
      "remainder not below divisor")
   `MRT_ASSERT_NEXT(a_hold_when_stalled, !adv, $stable(valid_c_ff) && $stable(quo_c_ff),
      "divider output moved while held")

endmodule

// File: rtl/mixed_radix_time_add_sub_top.sv
// signed hours:minutes:seconds.millis add/sub with saturation and compare flags
// pipeline: front stages, hour, seconds and minutes dividers, output register
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// the hour divide by 3600000 sets the depth: reciprocal multiply then back-multiply
// reset clears every valid bit; payload registers are not reset
`include "mixed_radix_time_add_sub_top_macros.svh"

module mixed_radix_time_add_sub_top
   import mrt_pkg::*;
#(
   parameter int MAX_HOURS = 999
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic signed [HOURS_FW-1:0]   req_a_hours,
   input  logic signed [MINSEC_FW-1:0]  req_a_minutes,
   input  logic signed [MINSEC_FW-1:0]  req_a_seconds,
   input  logic signed [MILLIS_FW-1:0]  req_a_millis,
   input  logic signed [HOURS_FW-1:0]   req_b_hours,
   input  logic signed [MINSEC_FW-1:0]  req_b_minutes,
   input  logic signed [MINSEC_FW-1:0]  req_b_seconds,
   input  logic signed [MILLIS_FW-1:0]  req_b_millis,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [HOURS_FW-1:0]   rsp_r_hours,
   output logic signed [MINSEC_FW-1:0]  rsp_r_minutes,
   output logic signed [MINSEC_FW-1:0]  rsp_r_seconds,
   output logic signed [MILLIS_FW-1:0]  rsp_r_millis,
   output logic                         rsp_overflow,
   output logic                         rsp_a_greater,
   output logic                         rsp_operands_equal,
   output logic                         rsp_result_zero,
   output logic                         rsp_result_negative
);

   localparam int LIM_W = $clog2(MAX_HOURS + 2) + HR_DIV_W;
   localparam logic [LIM_W-1:0] LIMIT =
      LIM_W'(MAX_HOURS) * LIM_W'(HOUR_MS) + LIM_W'(HOUR_MS - 1);

   logic adv;

   // stage 1: field products and operand compare
   logic signed [OPD_W-1:0] a_term_in [4];
   logic signed [OPD_W-1:0] b_term_in [4];
   logic signed [OPD_W-1:0] a_term_ff [4];
   logic signed [OPD_W-1:0] b_term_ff [4];
   logic greater_in, equal_in;
   logic valid1_ff, func1_ff, greater1_ff, equal1_ff;

   // stage 2: operand totals
   logic signed [OPD_W-1:0] opa_in, opb_in, opa_ff, opb_ff;
   logic valid2_ff, func2_ff, greater2_ff, equal2_ff;

   // stage 3: sum or difference
   logic signed [OPD_W-1:0] total_in, total_ff;
   logic valid3_ff, greater3_ff, equal3_ff;

   // stage 4: magnitude
   logic             neg4_in;
   logic [MAG_W-1:0] mag4_in, mag4_ff;
   logic valid4_ff, greater4_ff, equal4_ff, neg4_ff;

   // stage 5: saturation
   logic             ovf5_in;
   logic [MAG_W-1:0] mag5_in, mag5_ff;
   flags_type        flags5_in, flags5_ff;
   logic             valid5_ff;

   // divider chain
   logic                 valid_h, valid_s, valid_m;
   logic [HRS_W-1:0]     hours_h;
   logic [HMS_REM_W-1:0] rem_h;
   flags_type            flags_h;
   sside_type            side_s_in, side_s;
   logic [TOT_S_W-1:0]   tot_s;
   logic [MS_W-1:0]      millis_s;
   mside_type            side_m_in, side_m;
   logic [MIN_W-1:0]     minutes_m;
   logic [SEC_W-1:0]     seconds_m;

   // output register
   logic signed [HOURS_FW-1:0]  r_hours_in, r_hours_ff;
   logic signed [MINSEC_FW-1:0] r_minutes_in, r_minutes_ff;
   logic signed [MINSEC_FW-1:0] r_seconds_in, r_seconds_ff;
   logic signed [MILLIS_FW-1:0] r_millis_in, r_millis_ff;
   logic zero_in;
   logic rsp_valid_ff, ovf_ff, greater_ff, equal_ff, zero_ff, negative_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // stage 1
   assign a_term_in[0] = OPD_W'(req_a_hours) * HOUR_MS_S;
   assign a_term_in[1] = OPD_W'(req_a_minutes) * MIN_MS_S;
   assign a_term_in[2] = OPD_W'(req_a_seconds) * SEC_MS_S;
   assign a_term_in[3] = OPD_W'(req_a_millis);
   assign b_term_in[0] = OPD_W'(req_b_hours) * HOUR_MS_S;
   assign b_term_in[1] = OPD_W'(req_b_minutes) * MIN_MS_S;
   assign b_term_in[2] = OPD_W'(req_b_seconds) * SEC_MS_S;
   assign b_term_in[3] = OPD_W'(req_b_millis);

   always_comb begin
      if (req_a_hours != req_b_hours) begin
         greater_in = req_a_hours > req_b_hours;
      end else if (req_a_minutes != req_b_minutes) begin
         greater_in = req_a_minutes > req_b_minutes;
      end else if (req_a_seconds != req_b_seconds) begin
         greater_in = req_a_seconds > req_b_seconds;
      end else begin
         greater_in = req_a_millis > req_b_millis;
      end
   end

   assign equal_in = (req_a_hours == req_b_hours) && (req_a_minutes == req_b_minutes) &&
                     (req_a_seconds == req_b_seconds) && (req_a_millis == req_b_millis);

   // stages 2 to 5
   assign opa_in   = a_term_ff[0] + a_term_ff[1] + a_term_ff[2] + a_term_ff[3];
   assign opb_in   = b_term_ff[0] + b_term_ff[1] + b_term_ff[2] + b_term_ff[3];
   assign total_in = func2_ff ? (opa_ff - opb_ff) : (opa_ff + opb_ff);
   assign neg4_in  = total_ff[OPD_W-1];
   assign mag4_in  = neg4_in ? MAG_W'(-total_ff) : MAG_W'(total_ff);
   assign ovf5_in  = mag4_ff > LIMIT;
   assign mag5_in  = ovf5_in ? MAG_W'(LIMIT) : mag4_ff;

   always_comb begin
      flags5_in.ovf     = ovf5_in;
      flags5_in.greater = greater4_ff;
      flags5_in.equal   = equal4_ff;
      flags5_in.neg     = neg4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (adv) begin
         valid1_ff <= req_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_term_ff   <= a_term_in;
         b_term_ff   <= b_term_in;
         func1_ff    <= req_func;
         greater1_ff <= greater_in;
         equal1_ff   <= equal_in;
         opa_ff      <= opa_in;
         opb_ff      <= opb_in;
         func2_ff    <= func1_ff;
         greater2_ff <= greater1_ff;
         equal2_ff   <= equal1_ff;
         total_ff    <= total_in;
         greater3_ff <= greater2_ff;
         equal3_ff   <= equal2_ff;
         mag4_ff     <= mag4_in;
         neg4_ff     <= neg4_in;
         greater4_ff <= greater3_ff;
         equal4_ff   <= equal3_ff;
         mag5_ff     <= mag5_in;
         flags5_ff   <= flags5_in;
      end
   end

   // hours and remaining milliseconds
   mrt_cdiv #(
      .NUM_W(MAG_W), .SHIFT(HR_SHIFT), .MUL_W(HR_MUL_W), .RECIP(HR_RECIP), .K(HR_K),
      .DIV_W(HR_DIV_W), .DIVISOR(HR_DIV), .QUO_W(HRS_W), .REM_W(HMS_REM_W),
      .side_type(flags_type)
   ) u_hdiv (
      .clock(clock), .reset(reset), .adv(adv),
      .valid_in(valid5_ff), .num_in(mag5_ff), .side_in(flags5_ff),
      .valid_out(valid_h), .quo_out(hours_h), .rem_out(rem_h), .side_out(flags_h)
   );

   always_comb begin
      side_s_in.flags = flags_h;
      side_s_in.hours = hours_h;
   end

   // total seconds and milliseconds
   mrt_cdiv #(
      .NUM_W(HMS_REM_W), .SHIFT(SC_SHIFT), .MUL_W(SC_MUL_W), .RECIP(SC_RECIP), .K(SC_K),
      .DIV_W(SC_DIV_W), .DIVISOR(SC_DIV), .QUO_W(TOT_S_W), .REM_W(MS_W),
      .side_type(sside_type)
   ) u_sdiv (
      .clock(clock), .reset(reset), .adv(adv),
      .valid_in(valid_h), .num_in(rem_h), .side_in(side_s_in),
      .valid_out(valid_s), .quo_out(tot_s), .rem_out(millis_s), .side_out(side_s)
   );

   always_comb begin
      side_m_in.flags  = side_s.flags;
      side_m_in.hours  = side_s.hours;
      side_m_in.millis = millis_s;
   end

   // minutes and seconds
   mrt_cdiv #(
      .NUM_W(TOT_S_W), .SHIFT(MN_SHIFT), .MUL_W(MN_MUL_W), .RECIP(MN_RECIP), .K(MN_K),
      .DIV_W(MN_DIV_W), .DIVISOR(MN_DIV), .QUO_W(MIN_W), .REM_W(SEC_W),
      .side_type(mside_type)
   ) u_mdiv (
      .clock(clock), .reset(reset), .adv(adv),
      .valid_in(valid_s), .num_in(tot_s), .side_in(side_m_in),
      .valid_out(valid_m), .quo_out(minutes_m), .rem_out(seconds_m), .side_out(side_m)
   );

   // apply the sign to every field
   always_comb begin
      if (side_m.flags.neg) begin
         r_hours_in   = HOURS_FW'(0) - HOURS_FW'(side_m.hours);
         r_minutes_in = MINSEC_FW'(0) - MINSEC_FW'(minutes_m);
         r_seconds_in = MINSEC_FW'(0) - MINSEC_FW'(seconds_m);
         r_millis_in  = MILLIS_FW'(0) - MILLIS_FW'(side_m.millis);
      end else begin
         r_hours_in   = HOURS_FW'(side_m.hours);
         r_minutes_in = MINSEC_FW'(minutes_m);
         r_seconds_in = MINSEC_FW'(seconds_m);
         r_millis_in  = MILLIS_FW'(side_m.millis);
      end
   end

   assign zero_in = (r_hours_in == '0) && (r_minutes_in == '0) &&
                    (r_seconds_in == '0) && (r_millis_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_m;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_hours_ff   <= r_hours_in;
         r_minutes_ff <= r_minutes_in;
         r_seconds_ff <= r_seconds_in;
         r_millis_ff  <= r_millis_in;
         ovf_ff       <= side_m.flags.ovf;
         greater_ff   <= side_m.flags.greater;
         equal_ff     <= side_m.flags.equal;
         zero_ff      <= zero_in;
         negative_ff  <= side_m.flags.neg;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_r_hours         = r_hours_ff;
   assign rsp_r_minutes       = r_minutes_ff;
   assign rsp_r_seconds       = r_seconds_ff;
   assign rsp_r_millis        = r_millis_ff;
   assign rsp_overflow        = ovf_ff;
   assign rsp_a_greater       = greater_ff;
   assign rsp_operands_equal  = equal_ff;
   assign rsp_result_zero     = zero_ff;
   assign rsp_result_negative = negative_ff;

   `MRT_ASSERT_NOW(a_equal_not_greater, rsp_valid_ff && equal_ff, !greater_ff,
      "equal operands flagged as greater")
   `MRT_ASSERT_NOW(a_overflow_saturates, rsp_valid_ff && ovf_ff,
      (r_minutes_ff == 7'sd59) || (r_minutes_ff == -7'sd59),
      "overflow without saturated minutes")
   `MRT_ASSERT_NOW(a_negative_fields, rsp_valid_ff && negative_ff,
      (r_minutes_ff <= 7'sd0) && (r_seconds_ff <= 7'sd0) && (r_millis_ff <= 11'sd0),
      "negative result with a positive field")

endmodule

// File: bench/tb_mixed_radix_time_add_sub_top.sv
// testbench for the mixed-radix time add/sub block, checked against its own predictor
module tb_mixed_radix_time_add_sub_top;
   import mrt_pkg::*;

   localparam int MAX_HRS      = 999;
   localparam int MIN_MS       = 60000;
   localparam int SEC_MS       = 1000;
   localparam int ITEMS_PER_PHASE = 412;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 30;
   localparam bit OP_ADD       = 1'b0;
   localparam bit OP_SUB       = 1'b1;

   typedef struct {
      logic signed [HOURS_FW-1:0]  hours;
      logic signed [MINSEC_FW-1:0] minutes;
      logic signed [MINSEC_FW-1:0] seconds;
      logic signed [MILLIS_FW-1:0] millis;
   } time_value_type;

   typedef struct {
      bit             func;
      time_value_type a;
      time_value_type b;
   } operands_type;

   typedef struct {
      time_value_type r;
      bit             overflow;
      bit             a_greater;
      bit             operands_equal;
      bit             result_zero;
      bit             result_negative;
   } time_result_type;

   class time_sum_scoreboard;
      time_result_type sums_due[$];
      int unsigned     mismatches;

      function new();
         mismatches = 0;
      endfunction

      function automatic longint to_millis(time_value_type t);
         return longint'(t.hours) * HOUR_MS + longint'(t.minutes) * MIN_MS
            + longint'(t.seconds) * SEC_MS + longint'(t.millis);
      endfunction

      function automatic time_result_type predict_sum(operands_type op);
         time_result_type res;
         longint total, mag, limit, h, mi, s, ms;
         bit neg;
         if (op.a.hours != op.b.hours)
            res.a_greater = op.a.hours > op.b.hours;
         else if (op.a.minutes != op.b.minutes)
            res.a_greater = op.a.minutes > op.b.minutes;
         else if (op.a.seconds != op.b.seconds)
            res.a_greater = op.a.seconds > op.b.seconds;
         else
            res.a_greater = op.a.millis > op.b.millis;
         res.operands_equal = op.a.hours == op.b.hours && op.a.minutes == op.b.minutes
            && op.a.seconds == op.b.seconds && op.a.millis == op.b.millis;
         if (op.func == OP_SUB)
            total = to_millis(op.a) - to_millis(op.b);
         else
            total = to_millis(op.a) + to_millis(op.b);
         neg = total < 0;
         mag = neg ? -total : total;
         limit = longint'(MAX_HRS) * HOUR_MS + HOUR_MS - 1;
         res.overflow = mag > limit;
         if (res.overflow)
            mag = limit;
         h  = mag / HOUR_MS;
         mi = (mag / MIN_MS) % 60;
         s  = (mag / SEC_MS) % 60;
         ms = mag % SEC_MS;
         if (neg) begin
            h  = -h;
            mi = -mi;
            s  = -s;
            ms = -ms;
         end
         res.r.hours   = h[HOURS_FW-1:0];
         res.r.minutes = mi[MINSEC_FW-1:0];
         res.r.seconds = s[MINSEC_FW-1:0];
         res.r.millis  = ms[MILLIS_FW-1:0];
         res.result_zero = res.r.hours == 0 && res.r.minutes == 0
            && res.r.seconds == 0 && res.r.millis == 0;
         res.result_negative = neg && mag != 0;
         return res;
      endfunction

      function void note_operands(operands_type op);
         sums_due.push_back(predict_sum(op));
      endfunction

      function int pending();
         return sums_due.size();
      endfunction

      function void compare_field(string field, longint want, longint got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on %s: expected %0d, got %0d", field, want, got);
         end
      endfunction

      function void check_result(time_result_type got);
         time_result_type want;
         if (sums_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result arrived with no item outstanding");
            return;
         end
         want = sums_due.pop_front();
         compare_field("r_hours", want.r.hours, got.r.hours);
         compare_field("r_minutes", want.r.minutes, got.r.minutes);
         compare_field("r_seconds", want.r.seconds, got.r.seconds);
         compare_field("r_millis", want.r.millis, got.r.millis);
         compare_field("overflow", want.overflow, got.overflow);
         compare_field("a_greater", want.a_greater, got.a_greater);
         compare_field("operands_equal", want.operands_equal, got.operands_equal);
         compare_field("result_zero", want.result_zero, got.result_zero);
         compare_field("result_negative", want.result_negative, got.result_negative);
      endfunction
   endclass

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_func = 1'b0;
   logic signed [HOURS_FW-1:0]  req_a_hours = '0;
   logic signed [MINSEC_FW-1:0] req_a_minutes = '0;
   logic signed [MINSEC_FW-1:0] req_a_seconds = '0;
   logic signed [MILLIS_FW-1:0] req_a_millis = '0;
   logic signed [HOURS_FW-1:0]  req_b_hours = '0;
   logic signed [MINSEC_FW-1:0] req_b_minutes = '0;
   logic signed [MINSEC_FW-1:0] req_b_seconds = '0;
   logic signed [MILLIS_FW-1:0] req_b_millis = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [HOURS_FW-1:0]  rsp_r_hours;
   logic signed [MINSEC_FW-1:0] rsp_r_minutes;
   logic signed [MINSEC_FW-1:0] rsp_r_seconds;
   logic signed [MILLIS_FW-1:0] rsp_r_millis;
   logic                        rsp_overflow;
   logic                        rsp_a_greater;
   logic                        rsp_operands_equal;
   logic                        rsp_result_zero;
   logic                        rsp_result_negative;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;

   time_sum_scoreboard board = new();

   mixed_radix_time_add_sub_top #(.MAX_HOURS(MAX_HRS)) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_a_hours         (req_a_hours),
      .req_a_minutes       (req_a_minutes),
      .req_a_seconds       (req_a_seconds),
      .req_a_millis        (req_a_millis),
      .req_b_hours         (req_b_hours),
      .req_b_minutes       (req_b_minutes),
      .req_b_seconds       (req_b_seconds),
      .req_b_millis        (req_b_millis),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_r_hours         (rsp_r_hours),
      .rsp_r_minutes       (rsp_r_minutes),
      .rsp_r_seconds       (rsp_r_seconds),
      .rsp_r_millis        (rsp_r_millis),
      .rsp_overflow        (rsp_overflow),
      .rsp_a_greater       (rsp_a_greater),
      .rsp_operands_equal  (rsp_operands_equal),
      .rsp_result_zero     (rsp_result_zero),
      .rsp_result_negative (rsp_result_negative)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_mixed_radix_time_add_sub_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= $urandom_range(99) < stall_pct;
   end

   always @(posedge clock) begin
      time_result_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.r.hours         = rsp_r_hours;
         seen.r.minutes       = rsp_r_minutes;
         seen.r.seconds       = rsp_r_seconds;
         seen.r.millis        = rsp_r_millis;
         seen.overflow        = rsp_overflow;
         seen.a_greater       = rsp_a_greater;
         seen.operands_equal  = rsp_operands_equal;
         seen.result_zero     = rsp_result_zero;
         seen.result_negative = rsp_result_negative;
         board.check_result(seen);
      end
   end

   function automatic operands_type mk(bit f, int ah, int am, int as_, int ams,
                                       int bh, int bm, int bs, int bms);
      operands_type op;
      op.func = f;
      op.a.hours = HOURS_FW'(ah);
      op.a.minutes = MINSEC_FW'(am);
      op.a.seconds = MINSEC_FW'(as_);
      op.a.millis = MILLIS_FW'(ams);
      op.b.hours = HOURS_FW'(bh);
      op.b.minutes = MINSEC_FW'(bm);
      op.b.seconds = MINSEC_FW'(bs);
      op.b.millis = MILLIS_FW'(bms);
      return op;
   endfunction

   function automatic int pick_digit(int top);
      case ($urandom_range(4))
         0: return 0;
         1: return top;
         default: return $urandom_range(top);
      endcase
   endfunction

   function automatic time_value_type canonical_time();
      time_value_type t;
      int sgn;
      sgn = $urandom_range(1) ? -1 : 1;
      t.hours   = HOURS_FW'(sgn * pick_digit(MAX_HRS));
      t.minutes = MINSEC_FW'(sgn * pick_digit(59));
      t.seconds = MINSEC_FW'(sgn * pick_digit(59));
      t.millis  = MILLIS_FW'(sgn * pick_digit(999));
      return t;
   endfunction

   function automatic time_value_type noise_time();
      time_value_type t;
      t.hours   = HOURS_FW'($urandom);
      t.minutes = MINSEC_FW'($urandom);
      t.seconds = MINSEC_FW'($urandom);
      t.millis  = MILLIS_FW'($urandom);
      return t;
   endfunction

   function automatic operands_type random_operands();
      operands_type op;
      int step;
      op.func = 1'($urandom_range(1));
      op.a = canonical_time();
      op.b = canonical_time();
      step = $urandom_range(1) ? -1 : 1;
      case ($urandom_range(9))
         0: op.b = op.a;
         1: begin
            op.b.hours   = -op.a.hours;
            op.b.minutes = -op.a.minutes;
            op.b.seconds = -op.a.seconds;
            op.b.millis  = -op.a.millis;
         end
         2: begin
            op.b = op.a;
            case ($urandom_range(3))
               0: op.b.hours   = HOURS_FW'(op.a.hours + step);
               1: op.b.minutes = MINSEC_FW'(op.a.minutes + step);
               2: op.b.seconds = MINSEC_FW'(op.a.seconds + step);
               default: op.b.millis = MILLIS_FW'(op.a.millis + step);
            endcase
         end
         3: begin
            op.a = noise_time();
            op.b = noise_time();
         end
         default: ;
      endcase
      return op;
   endfunction

   task automatic drive_item(input operands_type op);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= op.func;
      req_a_hours   <= op.a.hours;
      req_a_minutes <= op.a.minutes;
      req_a_seconds <= op.a.seconds;
      req_a_millis  <= op.a.millis;
      req_b_hours   <= op.b.hours;
      req_b_minutes <= op.b.minutes;
      req_b_seconds <= op.b.seconds;
      req_b_millis  <= op.b.millis;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_operands(op);
   endtask

   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero and sign corners
      drive_item(mk(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_item(mk(OP_SUB, 0, 0, 0, 0, 0, 0, 0, 0));
      drive_item(mk(OP_SUB, 0, 0, 0, 1, 0, 0, 0, 2));
      drive_item(mk(OP_ADD, 7, 30, 0, 500, -7, -30, 0, -500));
      // saturation at both signs
      drive_item(mk(OP_ADD, 999, 59, 59, 999, 999, 59, 59, 999));
      drive_item(mk(OP_ADD, -999, -59, -59, -999, -999, -59, -59, -999));
      drive_item(mk(OP_SUB, 999, 59, 59, 999, -999, -59, -59, -999));
      drive_item(mk(OP_SUB, 999, 59, 59, 999, 999, 59, 59, 999));
      drive_item(mk(OP_ADD, 999, 59, 59, 999, 0, 0, 0, 0));
      drive_item(mk(OP_ADD, 999, 59, 59, 999, 0, 0, 0, 1));
      drive_item(mk(OP_SUB, -999, -59, -59, -999, 0, 0, 0, 1));
      // borrows with only hours and millis set, then carries out of millis
      drive_item(mk(OP_SUB, 5, 0, 0, 0, 0, 0, 0, 1));
      drive_item(mk(OP_ADD, -5, 0, 0, 0, 0, 0, 0, 1));
      drive_item(mk(OP_ADD, 0, 59, 59, 999, 0, 0, 0, 1));
      drive_item(mk(OP_ADD, 0, 0, 0, 999, 0, 0, 0, 1));
      // comparison decided at each field
      drive_item(mk(OP_SUB, 1, 2, 3, 4, 1, 2, 3, 5));
      drive_item(mk(OP_SUB, 1, 2, 4, 0, 1, 2, 3, 999));
      drive_item(mk(OP_SUB, 1, 3, 0, 0, 1, 2, 59, 999));
      drive_item(mk(OP_SUB, -1, 0, 0, 0, -2, 0, 0, 0));
      // raw field extremes and mixed signs
      drive_item(mk(OP_ADD, -1024, -64, -64, -1024, -1024, -64, -64, -1024));
      drive_item(mk(OP_SUB, -1024, -64, -64, -1024, 1023, 63, 63, 1023));
      drive_item(mk(OP_ADD, 1023, 63, 63, 1023, 1023, 63, 63, 1023));
      drive_item(mk(OP_SUB, 1, 0, 0, -1, 0, 0, 0, -1));
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 22; stall_pct = 22; end
         endcase
         repeat (ITEMS_PER_PHASE) drive_item(random_operands());
         drain_results();
      end

      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb_mixed_radix_time_add_sub_top: clean");
      else
         $display("tb_mixed_radix_time_add_sub_top: errors");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mrt_pkg.sv
rtl/mrt_cdiv.sv
rtl/mixed_radix_time_add_sub_top.sv
bench/tb_mixed_radix_time_add_sub_top.sv
